### hw/rtl/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
// Holds the transfer payload structs, event codes and register map.
// No dependencies.
`default_nettype none

package tgc_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned DELTA_W = 12;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// Register indexes on the configuration port.
	localparam logic REG_SWIPE_MIN = 1'b0;
	localparam logic REG_TAP_MAX = 1'b1;

	// Reset values of the thresholds.
	localparam logic [DELTA_W-1:0] SWIPE_MIN_RST = 12'd40;
	localparam logic [DELTA_W-1:0] TAP_MAX_RST = 12'd20;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_BACK = 3'd1,
		EV_CLICK = 3'd2,
		EV_UP = 3'd3,
		EV_DOWN = 3'd4,
		EV_LEFT = 3'd5,
		EV_RIGHT = 3'd6,
		EV_TAP = 3'd7
	} event_code_t;

	typedef struct packed {
		logic long_press;
		logic short_press;
		logic touch_down;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} in_item_t;

	typedef struct packed {
		event_code_t event_code;
		logic [COORD_W-1:0] tap_x;
		logic [COORD_W-1:0] tap_y;
	} out_item_t;

	typedef struct packed {
		logic [DELTA_W-1:0] swipe_thresh;
		logic [DELTA_W-1:0] tap_thresh;
	} cfg_t;

	typedef struct packed {
		logic finger_down;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] latest_x;
		logic [COORD_W-1:0] latest_y;
	} track_t;

endpackage

`default_nettype wire

### hw/rtl/tgc_cfg_regs.sv
// Threshold registers of the touch gesture classifier behind an APB-style port.
// Depends on tgc_pkg.
`default_nettype none

module tgc_cfg_regs import tgc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic wr_en;
	logic reg_idx;
	logic [DELTA_W-1:0] swipe_min_q;
	logic [DELTA_W-1:0] tap_max_q;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign reg_idx = paddr[2];

	// Register writes; the upper data bits are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_min_q <= SWIPE_MIN_RST;
			tap_max_q <= TAP_MAX_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SWIPE_MIN: swipe_min_q <= pwdata[DELTA_W-1:0];
				REG_TAP_MAX: tap_max_q <= pwdata[DELTA_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back of the selected register.
	always_comb begin
		case (reg_idx)
			REG_SWIPE_MIN: prdata = {{(APB_DATA_W-DELTA_W){1'b0}}, swipe_min_q};
			REG_TAP_MAX: prdata = {{(APB_DATA_W-DELTA_W){1'b0}}, tap_max_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.swipe_thresh = swipe_min_q;
	assign cfg.tap_thresh = tap_max_q;

endmodule

`default_nettype wire

### hw/rtl/tgc_track.sv
// Finger tracking state: contact flag, start point and latest point.
// Updated when a poll leaves the input stage. Depends on tgc_pkg.
`default_nettype none

module tgc_track import tgc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire in_item_t item,
	output track_t track
);

	logic finger_down_q;
	logic [COORD_W-1:0] start_x_q;
	logic [COORD_W-1:0] start_y_q;
	logic [COORD_W-1:0] latest_x_q;
	logic [COORD_W-1:0] latest_y_q;
	logic press;

	// A button press leaves the touch state alone.
	assign press = item.long_press | item.short_press;

	// The first contact sets the start point; every contact sets the latest point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_down_q <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
			latest_x_q <= '0;
			latest_y_q <= '0;
		end else if (adv && !press) begin
			if (item.touch_down) begin
				if (!finger_down_q) begin
					finger_down_q <= 1'b1;
					start_x_q <= item.touch_x;
					start_y_q <= item.touch_y;
				end
				latest_x_q <= item.touch_x;
				latest_y_q <= item.touch_y;
			end else begin
				finger_down_q <= 1'b0;
			end
		end
	end

	assign track.finger_down = finger_down_q;
	assign track.start_x = start_x_q;
	assign track.start_y = start_y_q;
	assign track.latest_x = latest_x_q;
	assign track.latest_y = latest_y_q;

	// A press must not disturb a gesture in progress.
	a_press_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && press |=> $stable(finger_down_q) && $stable(latest_x_q) && $stable(latest_y_q))
		else $error("touch state changed on a button press");

	// A release poll always ends the contact.
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !press && !item.touch_down |=> !finger_down_q)
		else $error("finger still down after a release poll");

endmodule

`default_nettype wire

### hw/rtl/tgc_classify.sv
// Combinational event decision for one poll: buttons first, then the swipe,
// tap or no-event choice on release. Depends on tgc_pkg.
`default_nettype none

module tgc_classify import tgc_pkg::*; (
	input  wire in_item_t item,
	input  wire track_t track,
	input  wire cfg_t cfg,
	output out_item_t result
);

	logic neg_x;
	logic neg_y;
	logic [COORD_W-1:0] ax;
	logic [COORD_W-1:0] ay;
	logic release_ev;
	logic swipe_v;
	logic swipe_h;
	logic tap_ok;

	// Magnitudes of the travel along each axis.
	assign neg_x = track.latest_x < track.start_x;
	assign neg_y = track.latest_y < track.start_y;
	assign ax = neg_x ? track.start_x - track.latest_x : track.latest_x - track.start_x;
	assign ay = neg_y ? track.start_y - track.latest_y : track.latest_y - track.start_y;

	assign release_ev = !item.long_press && !item.short_press && !item.touch_down
		&& track.finger_down;
	assign swipe_v = (ay >= cfg.swipe_thresh) && (ay > ax);
	assign swipe_h = (ax >= cfg.swipe_thresh) && (ax > ay);
	assign tap_ok = (ax < cfg.tap_thresh) && (ay < cfg.tap_thresh);

	// Priority decision; tap coordinates are zero for every other event.
	always_comb begin
		result.event_code = EV_NONE;
		result.tap_x = '0;
		result.tap_y = '0;
		if (item.long_press) begin
			result.event_code = EV_BACK;
		end else if (item.short_press) begin
			result.event_code = EV_CLICK;
		end else if (release_ev) begin
			if (swipe_v) begin
				result.event_code = neg_y ? EV_UP : EV_DOWN;
			end else if (swipe_h) begin
				result.event_code = neg_x ? EV_LEFT : EV_RIGHT;
			end else if (tap_ok) begin
				result.event_code = EV_TAP;
				result.tap_x = track.start_x;
				result.tap_y = track.start_y;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/touch_gesture_classifier_core.sv
// Touch gesture classifier: one poll in, one event out.
// The path from input transfer to result valid runs through one input stage and one
// result register, with the decision logic between them.
// Throughput is one poll per cycle unless the output stalls; the tracking state is
// updated as a poll leaves the input stage, so the next poll already sees it.
// Reset clears both stages, the tracking state, and loads the thresholds 40 and 20.
`default_nettype none

module touch_gesture_classifier_core import tgc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire in_item_t in_item,
	output logic out_valid,
	input  wire logic out_stall,
	output out_item_t out_item,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_item_q;
	logic adv;
	logic in_take;
	cfg_t cfg;
	track_t track;
	out_item_t result;

	tgc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	tgc_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.item(item_s1),
		.track(track)
	);

	tgc_classify u_classify (
		.item(item_s1),
		.track(track),
		.cfg(cfg),
		.result(result)
	);

	// The input stage moves on whenever the result register is free or being emptied.
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take = in_valid && !in_stall;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	// Tap coordinates only accompany a tap.
	a_tap_coords: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.event_code != EV_TAP
		|-> out_item_q.tap_x == '0 && out_item_q.tap_y == '0)
		else $error("tap coordinates set without a tap event");

	// No transfer is taken while both stages are full and the output is stalled.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |-> in_stall)
		else $error("input taken while the pipeline is full");

endmodule

`default_nettype wire

### tb/touch_gesture_classifier_core_tb.sv
// Self-checking testbench for touch_gesture_classifier_core: directed and random polls,
// threshold changes over the register port, random idling on both channels.
// Depends on tgc_pkg and the classifier core RTL.
`default_nettype none

module touch_gesture_classifier_core_tb;
	import tgc_pkg::*;

	localparam int COORD_MAX = 4095;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int PHASE_POLLS = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// Polls waiting to be driven and gesture events waiting to be seen.
	in_item_t pending_polls[$];
	out_item_t expected_events[$];
	int polls_queued = 0;
	int polls_taken = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	logic poll_taken = 1'b0;

	// Own copy of the tracking state and the thresholds.
	track_t trk = '0;
	cfg_t th_cfg = '{swipe_thresh: SWIPE_MIN_RST, tap_thresh: TAP_MAX_RST};

	// Sender burst control and receiver stall pattern.
	int burst_left = 0;
	int gap_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	logic rx_toggle = 1'b0;
	logic hold_req = 1'b0;
	int hold_left = 0;

	touch_gesture_classifier_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Works out the gesture event for one poll and advances the tracking state.
	function automatic out_item_t predict_event(input in_item_t p);
		out_item_t r;
		int dx, dy, ax, ay;
		r = '0;
		r.event_code = EV_NONE;
		if (p.long_press) begin
			r.event_code = EV_BACK;
		end else if (p.short_press) begin
			r.event_code = EV_CLICK;
		end else if (p.touch_down) begin
			if (!trk.finger_down) begin
				trk.finger_down = 1'b1;
				trk.start_x = p.touch_x;
				trk.start_y = p.touch_y;
			end
			trk.latest_x = p.touch_x;
			trk.latest_y = p.touch_y;
		end else if (trk.finger_down) begin
			trk.finger_down = 1'b0;
			dx = int'(trk.latest_x) - int'(trk.start_x);
			dy = int'(trk.latest_y) - int'(trk.start_y);
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			if (ay >= int'(th_cfg.swipe_thresh) && ay > ax) begin
				if (dy < 0) r.event_code = EV_UP;
				else r.event_code = EV_DOWN;
			end else if (ax >= int'(th_cfg.swipe_thresh) && ax > ay) begin
				if (dx < 0) r.event_code = EV_LEFT;
				else r.event_code = EV_RIGHT;
			end else if (ax < int'(th_cfg.tap_thresh) && ay < int'(th_cfg.tap_thresh)) begin
				r.event_code = EV_TAP;
				r.tap_x = trk.start_x;
				r.tap_y = trk.start_y;
			end
		end
		return r;
	endfunction

	task automatic queue_poll(input logic lp, input logic sp, input logic td,
			input int x, input int y);
		in_item_t p;
		p.long_press = lp;
		p.short_press = sp;
		p.touch_down = td;
		p.touch_x = x[COORD_W-1:0];
		p.touch_y = y[COORD_W-1:0];
		pending_polls.push_back(p);
		polls_queued++;
	endtask

	// A contact at the start point, some held samples, the end point and a release.
	// Optionally a press arrives just before the release and must not disturb the gesture.
	task automatic queue_gesture(input int sx, input int sy, input int ex, input int ey,
			input int holds, input logic with_press);
		queue_poll(1'b0, 1'b0, 1'b1, sx, sy);
		repeat (holds)
			queue_poll(1'b0, 1'b0, 1'b1, $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX));
		queue_poll(1'b0, 1'b0, 1'b1, ex, ey);
		if (with_press)
			queue_poll(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		queue_poll(1'b0, 1'b0, 1'b0, $urandom_range(0, COORD_MAX),
			$urandom_range(0, COORD_MAX));
	endtask

	// Travel chosen around the current thresholds, so that both edges get hit.
	function automatic int pick_travel();
		int sw, tp;
		sw = int'(th_cfg.swipe_thresh);
		tp = int'(th_cfg.tap_thresh);
		case ($urandom_range(0, 4))
			0, 1: return $urandom_range(0, (tp < COORD_MAX) ? tp + 1 : COORD_MAX);
			2: return sw + $urandom_range(0, 2) - 1;
			default: return $urandom_range(0, COORD_MAX);
		endcase
	endfunction

	// Moves a coordinate by a travel in a random direction, staying on the panel.
	function automatic int offset_coord(input int base, input int travel);
		int pos;
		if ($urandom_range(0, 1)) travel = -travel;
		pos = base + travel;
		if (pos > COORD_MAX || pos < 0) pos = base - travel;
		if (pos > COORD_MAX) pos = COORD_MAX;
		if (pos < 0) pos = 0;
		return pos;
	endfunction

	// Mostly well-formed gestures with random content, plus some raw noise polls.
	task automatic queue_random_phase(input int n);
		int first, sx, sy, mx, my;
		first = polls_queued;
		while (polls_queued - first < n) begin
			if ($urandom_range(0, 6) == 0) begin
				queue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
			end else begin
				sx = $urandom_range(0, COORD_MAX);
				sy = $urandom_range(0, COORD_MAX);
				mx = pick_travel();
				my = ($urandom_range(0, 7) == 0) ? mx : pick_travel();
				queue_gesture(sx, sy, offset_coord(sx, mx), offset_coord(sy, my),
					$urandom_range(0, 3), $urandom_range(0, 5) == 0);
			end
		end
	endtask

	// Register write: a setup cycle, then an access cycle held until pready.
	task automatic write_reg(input logic idx, input logic [DELTA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SWIPE_MIN) th_cfg.swipe_thresh = val;
		else th_cfg.tap_thresh = val;
	endtask

	// Returns once every queued poll has been taken and every event has come back.
	task automatic wait_drained();
		do @(negedge clk); while (polls_taken != polls_queued || expected_events.size() != 0);
	endtask

	// Input driver: bursts of transfers separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !poll_taken) begin
			// Stalled: the payload stays as it is.
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_polls.size() != 0) begin
			in_valid <= 1'b1;
			in_item <= pending_polls.pop_front();
			if (burst_left <= 1) begin
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 16);
				gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
					: $urandom_range(0, 3);
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Output receiver: a stall pattern that changes mode now and then, plus a long hold-off.
	always @(negedge clk) begin
		logic stall_now;
		if (hold_req) begin
			hold_left = LONG_HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(20, 120);
		end else begin
			rx_mode_left--;
		end
		rx_toggle = ~rx_toggle;
		case (rx_mode)
			0: stall_now = 1'b0;
			1: stall_now = ($urandom_range(0, 3) == 0);
			2: stall_now = ($urandom_range(0, 3) != 0);
			default: stall_now = rx_toggle;
		endcase
		if (hold_left != 0) begin
			stall_now = 1'b1;
			hold_left--;
		end
		out_stall <= stall_now;
	end

	// Monitor: checks each result transfer, predicts for each input transfer, and
	// runs the watchdog.
	always @(posedge clk) begin
		out_item_t want;
		poll_taken = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result: event_code %0d, tap_x %0d, tap_y %0d",
						out_item.event_code, out_item.tap_x, out_item.tap_y);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					if (out_item.event_code !== want.event_code) begin
						$error("event_code: expected %0d, got %0d", want.event_code,
							out_item.event_code);
						fail_count++;
					end
					if (out_item.tap_x !== want.tap_x) begin
						$error("tap_x: expected %0d, got %0d", want.tap_x, out_item.tap_x);
						fail_count++;
					end
					if (out_item.tap_y !== want.tap_y) begin
						$error("tap_y: expected %0d, got %0d", want.tap_y, out_item.tap_y);
						fail_count++;
					end
				end
			end
			if (poll_taken) begin
				expected_events.push_back(predict_event(in_item));
				polls_taken++;
			end
			if (poll_taken || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Test sequence: reset, directed polls at the reset thresholds, then random phases.
	initial begin
		int swipe_set[7];
		int tap_set[7];
		swipe_set = '{40, 0, 4095, 25, 200, 1, 40};
		tap_set = '{20, 0, 4095, 60, 1, 4095, 20};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Button events, both together, and a release with no contact.
		queue_poll(1'b1, 1'b0, 1'b0, 0, 0);
		queue_poll(1'b0, 1'b1, 1'b1, COORD_MAX, COORD_MAX);
		queue_poll(1'b1, 1'b1, 1'b0, COORD_MAX, 0);
		queue_poll(1'b0, 1'b0, 1'b0, COORD_MAX, COORD_MAX);
		// Full-panel swipes in every direction.
		queue_gesture(0, 0, 0, COORD_MAX, 0, 1'b0);
		queue_gesture(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 1'b0);
		queue_gesture(COORD_MAX, COORD_MAX, 0, COORD_MAX, 0, 1'b0);
		queue_gesture(0, 0, COORD_MAX, 0, 0, 1'b0);
		// Tap just inside the limit, then a move too long for a tap and too short for a swipe.
		queue_gesture(COORD_MAX, COORD_MAX, 4076, 4076, 0, 1'b0);
		queue_gesture(500, 500, 530, 500, 0, 1'b0);
		// A press while the finger is down drops the sample; the release then gives a tap.
		queue_poll(1'b0, 1'b0, 1'b1, 500, 500);
		queue_poll(1'b1, 1'b0, 1'b1, 900, 500);
		queue_poll(1'b0, 1'b0, 1'b0, 0, 0);
		wait_drained();

		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_SWIPE_MIN, DELTA_W'(swipe_set[ph]));
			write_reg(REG_TAP_MAX, DELTA_W'(tap_set[ph]));
			@(posedge clk);
			queue_random_phase(PHASE_POLLS);
			// Hold the receiver off while the sender keeps offering, so the core fills up.
			if (ph == 1) hold_req = 1'b1;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
